// ===== rtl/float_argmax_pool_defines.svh =====
// assertion macros for the argmax pooling block
`ifndef FLOAT_ARGMAX_POOL_DEFINES_SVH
`define FLOAT_ARGMAX_POOL_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define FAP_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define FAP_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// ===== rtl/fap_pkg.sv =====
// shared constants and helpers for the argmax pooling block
package fap_pkg;
  localparam int MAX_CHANNELS_DEF = 1024;
  localparam int MAX_POOL_DEF     = 256;
  localparam logic CFG_CHANNEL_COUNT = 1'b0;
  localparam logic CFG_POOL_SIZE     = 1'b1;
  localparam int VAL_W = 32;
  localparam int POS_W = 8;
  localparam int CH_W  = 10;

  function automatic logic fp_is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] fp_key(input logic [31:0] v);
    logic [31:0] t;
    t = (v == 32'h8000_0000) ? 32'd0 : v;
    return t[31] ? ~t : (t | 32'h8000_0000);
  endfunction

  function automatic logic fp_greater(input logic [31:0] a, input logic [31:0] b);
    if (fp_is_nan(a) || fp_is_nan(b)) return 1'b0;
    return fp_key(a) > fp_key(b);
  endfunction
endpackage

// ===== rtl/fap_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module fap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/fap_ctrl.sv =====
// channel and element counters with configuration registers
module fap_ctrl import fap_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_POOL     = MAX_POOL_DEF,
  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int EW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  input  logic          cfg_index,
  input  logic          cfg_known,
  input  logic [10:0]   cfg_data,
  input  logic          step,
  output logic [AW-1:0] ch,
  output logic [EW-1:0] el,
  output logic          first_el,
  output logic          last_el,
  output logic          last_ch
);
  logic [10:0]   chn_r, chn_nxt;
  logic [8:0]    pool_r, pool_nxt;
  logic [AW-1:0] ch_r, ch_nxt;
  logic [EW-1:0] el_r, el_nxt;
  logic [16:0]   chn_eff, pool_eff;

  always_comb begin
    chn_eff = (chn_r == 11'd0) ? 17'd1 : 17'(chn_r);
    if (chn_eff > 17'(MAX_CHANNELS)) chn_eff = 17'(MAX_CHANNELS);
    pool_eff = (pool_r == 9'd0) ? 17'd1 : 17'(pool_r);
    if (pool_eff > 17'(MAX_POOL)) pool_eff = 17'(MAX_POOL);
  end

  assign ch       = ch_r;
  assign el       = el_r;
  assign first_el = (el_r == '0);
  assign last_el  = (17'(el_r) == pool_eff - 17'd1);
  assign last_ch  = (17'(ch_r) == chn_eff - 17'd1);

  always_comb begin
    chn_nxt = chn_r;
    pool_nxt = pool_r;
    ch_nxt = ch_r;
    el_nxt = el_r;
    if (cfg_valid && cfg_known) begin
      if (cfg_index == CFG_CHANNEL_COUNT) chn_nxt = cfg_data;
      else pool_nxt = cfg_data[8:0];
      ch_nxt = '0;
      el_nxt = '0;
    end else if (step) begin
      if (last_ch) begin
        ch_nxt = '0;
        el_nxt = last_el ? '0 : el_r + EW'(1);
      end else begin
        ch_nxt = ch_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chn_r <= 11'd1;
      pool_r <= 9'd1;
      ch_r <= '0;
      el_r <= '0;
    end else begin
      chn_r <= chn_nxt;
      pool_r <= pool_nxt;
      ch_r <= ch_nxt;
      el_r <= el_nxt;
    end
  end
endmodule

// ===== rtl/float_argmax_pool.sv =====
// Argmax pooling over fp32 words. Words of one pixel arrive element-major, one
// sample per channel per element; per-channel running max and index live in a
// ram with registered read. One word is taken every cycle: the ram read is issued
// at accept, and the compare and ram write happen in the compare stage. A word on
// the last element puts its result into the output register as it leaves that
// stage, which raises out_valid. A word written to the ram at the edge where the
// next word is read is forwarded from a copy of that write. If a result is waiting
// in the output register and out_ready is low, a last-element word in the compare
// stage is held and in_ready drops until the output register drains. in_ready is
// also low while a configuration word is offered.
module float_argmax_pool import fap_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_POOL     = MAX_POOL_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_max_value,
  output logic [7:0]  out_max_index,
  output logic [9:0]  out_channel_number,
  output logic        out_pixel_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int EW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int MW = VAL_W + POS_W;

  logic          acc;
  logic [AW-1:0] ch;
  logic [EW-1:0] el;
  logic          first_el, last_el, last_ch;

  logic          s1_v_r;
  logic [31:0]   s1_samp_r;
  logic [AW-1:0] s1_ch_r;
  logic [EW-1:0] s1_el_r;
  logic          s1_first_r, s1_last_el_r, s1_last_ch_r;

  logic          wb_v_r;
  logic [AW-1:0] wb_ch_r;
  logic [MW-1:0] wb_data_r;

  logic [MW-1:0] rd, cur, upd;
  logic          ov_r;
  logic [31:0]   ov_val_r;
  logic [7:0]    ov_idx_r;
  logic [9:0]    ov_ch_r;
  logic          ov_end_r;
  logic          emit;
  logic          stall;
  logic          adv;
  logic [AW-1:0] raddr;

  assign cfg_ready = 1'b1;
  // hold the compare stage while its result cannot enter the output register
  assign stall = s1_v_r && s1_last_el_r && ov_r && !out_ready;
  assign adv = s1_v_r && !stall;
  assign in_ready = !stall && !cfg_valid;
  assign acc = in_valid && in_ready;
  assign raddr = stall ? s1_ch_r : ch;

  fap_ctrl #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_POOL(MAX_POOL)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index[0]), .cfg_known(1'b1),
    .cfg_data(cfg_data[10:0]), .step(acc),
    .ch(ch), .el(el), .first_el(first_el), .last_el(last_el), .last_ch(last_ch)
  );

  fap_ram #(.WIDTH(MW), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(adv), .waddr(s1_ch_r), .wdata(upd),
    .raddr(raddr), .rdata(rd)
  );

  always_comb begin
    cur = (wb_v_r && wb_ch_r == s1_ch_r) ? wb_data_r : rd;
    if (s1_first_r || fp_greater(s1_samp_r, cur[MW-1:POS_W]))
      upd = {s1_samp_r, POS_W'(s1_el_r)};
    else
      upd = cur;
  end

  assign emit = adv && s1_last_el_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      wb_v_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      s1_v_r <= acc || stall;
      wb_v_r <= adv;
      if (emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_samp_r <= in_sample;
      s1_ch_r <= ch;
      s1_el_r <= el;
      s1_first_r <= first_el;
      s1_last_el_r <= last_el;
      s1_last_ch_r <= last_ch;
    end
    wb_ch_r <= s1_ch_r;
    wb_data_r <= upd;
    if (emit) begin
      ov_val_r <= upd[MW-1:POS_W];
      ov_idx_r <= upd[POS_W-1:0];
      ov_ch_r <= CH_W'(s1_ch_r);
      ov_end_r <= s1_last_ch_r;
    end
  end

  assign out_valid = ov_r;
  assign out_max_value = ov_val_r;
  assign out_max_index = ov_idx_r;
  assign out_channel_number = ov_ch_r;
  assign out_pixel_end = ov_end_r;
endmodule

// ===== rtl/fap_checker.sv =====
// port-level checks for the argmax pooling block
`include "float_argmax_pool_defines.svh"
module fap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_max_value,
  input logic        cfg_valid
);
  `FAP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_max_value))
  `FAP_ASSERT_IMP(a_cfg_blocks_in, clk, rst_n, cfg_valid, !in_ready)
  `FAP_ASSERT_NXT(a_no_early_out, clk, rst_n, !out_valid && !(in_valid && in_ready) && !$past(in_valid && in_ready), !out_valid)
endmodule

bind float_argmax_pool fap_checker u_fap_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_max_value(out_max_value),
  .cfg_valid(cfg_valid)
);

// ===== tb/sv/tb_top.sv =====
// testbench for the fp32 argmax pooling block: predictor-checked random and table-driven words
module tb_top import fap_pkg::*; ();

  typedef struct packed {
    logic [31:0] val;
    logic [7:0]  idx;
    logic [9:0]  ch;
    logic        pe;
  } pool_res_t;

  typedef struct {
    logic [31:0] sample;
    bit          typed;
    logic [31:0] exp_val;
    logic [7:0]  exp_idx;
  } stim_row_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 6;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_sample;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_max_value;
  logic [7:0]  out_max_index;
  logic [9:0]  out_channel_number;
  logic        out_pixel_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;

  float_argmax_pool u_top (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [31:0] best_val [MAX_CHANNELS_DEF];
  logic [7:0]  best_pos [MAX_CHANNELS_DEF];
  int          ch_cnt, el_cnt;
  int          reg_channels, reg_pool;
  pool_res_t   pending_max[$];

  int  fail_cnt;
  int  idle_cycles;
  bit  hold_req;
  bit  quiet;
  bit  sender_idle;

  function automatic bit sample_is_nan(logic [31:0] v);
    return (&v[30:23]) && (|v[22:0]);
  endfunction

  function automatic bit sample_beats(logic [31:0] a, logic [31:0] b);
    longint ka, kb;
    if (sample_is_nan(a) || sample_is_nan(b)) return 1'b0;
    ka = a[31] ? -longint'(a[30:0]) : longint'(a[30:0]);
    kb = b[31] ? -longint'(b[30:0]) : longint'(b[30:0]);
    return ka > kb;
  endfunction

  // updates the running max, gives the channel result in r and returns whether the word is on the last element
  function automatic bit pool_predict(logic [31:0] s, output pool_res_t r);
    int nch, npool, c, e;
    bit last_el, last_ch;
    nch   = (reg_channels == 0) ? 1 : (reg_channels > MAX_CHANNELS_DEF ? MAX_CHANNELS_DEF
                                                                       : reg_channels);
    npool = (reg_pool == 0) ? 1 : (reg_pool > MAX_POOL_DEF ? MAX_POOL_DEF : reg_pool);
    c = (ch_cnt >= nch) ? nch - 1 : ch_cnt;
    e = (el_cnt >= npool) ? npool - 1 : el_cnt;
    last_el = (e == npool - 1);
    last_ch = (c == nch - 1);
    if (e == 0 || sample_beats(s, best_val[c])) begin
      best_val[c] = s;
      best_pos[c] = e[7:0];
    end
    r = '{val: best_val[c], idx: best_pos[c], ch: c[9:0], pe: last_ch};
    if (last_ch) begin
      ch_cnt = 0;
      el_cnt = last_el ? 0 : e + 1;
    end else begin
      ch_cnt = c + 1;
      el_cnt = e;
    end
    return last_el;
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_CHANNEL_COUNT) reg_channels = int'(data[10:0]);
    else reg_pool = int'(data[8:0]);
    ch_cnt = 0;
    el_cnt = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(logic [31:0] s, bit typed, logic [31:0] tv, logic [7:0] ti);
    pool_res_t r;
    if (!quiet && !sender_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    if (pool_predict(s, r)) begin
      if (typed) r = '{val: tv, idx: ti, ch: 10'd0, pe: 1'b1};
      pending_max.push_back(r);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_max.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return {$urandom_range(0, 1) == 1, 8'hff, 23'($urandom_range(1, 8388607))};
      1: return {$urandom_range(0, 1) == 1, 31'h7f80_0000};
      2: return {$urandom_range(0, 1) == 1, 31'd0};
      3: return {$urandom_range(0, 1) == 1, 8'h80, 23'($urandom_range(0, 3))};
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(int ch_val, int pool_val, int n_words);
    write_reg(CFG_CHANNEL_COUNT, {21'($urandom), 11'(ch_val)});
    write_reg(CFG_POOL_SIZE, {23'($urandom), 9'(pool_val)});
    repeat (n_words) send_word(rand_sample(), 1'b0, '0, '0);
    wait_drained();
  endtask

  stim_row_t dir_rows [] = '{
    '{32'h0000_0000, 1, 32'h0000_0000, 8'd0},
    '{32'hffff_ffff, 1, 32'hffff_ffff, 8'd0},
    '{32'h7f80_0000, 1, 32'h7f80_0000, 8'd0},
    '{32'hff80_0000, 1, 32'hff80_0000, 8'd0},
    '{32'h8000_0000, 1, 32'h8000_0000, 8'd0},
    '{32'h7fc0_0000, 1, 32'h7fc0_0000, 8'd0},
    // nan in first element sticks
    '{32'h7fc0_0001, 0, '0, '0}, '{32'h40a0_0000, 0, '0, '0}, '{32'h7f80_0000, 0, '0, '0},
    // plus and minus zero tie, first stays
    '{32'h0000_0000, 0, '0, '0}, '{32'h8000_0000, 0, '0, '0}, '{32'hbf80_0000, 0, '0, '0},
    // later nan ignored, equal value keeps earliest index
    '{32'h3f80_0000, 0, '0, '0}, '{32'hff80_0001, 0, '0, '0}, '{32'h3f80_0000, 0, '0, '0},
    // negatives, denormals, minus zero and the largest finite value
    '{32'hff7f_ffff, 0, '0, '0}, '{32'h8000_0001, 0, '0, '0}, '{32'h0000_0001, 0, '0, '0},
    '{32'h8000_0000, 0, '0, '0}, '{32'hc000_0000, 0, '0, '0}, '{32'h7f7f_ffff, 0, '0, '0}
  };

  always @(posedge clk) begin
    pool_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_max.size() == 0) begin
        $display("%0t: unexpected word val=%h idx=%0d ch=%0d end=%b", $time, out_max_value,
                 out_max_index, out_channel_number, out_pixel_end);
        fail_cnt++;
      end else begin
        e = pending_max.pop_front();
        if (out_max_value !== e.val) begin
          $display("%0t: max_value exp %h got %h", $time, e.val, out_max_value);
          fail_cnt++;
        end
        if (out_max_index !== e.idx) begin
          $display("%0t: max_index exp %0d got %0d", $time, e.idx, out_max_index);
          fail_cnt++;
        end
        if (out_channel_number !== e.ch) begin
          $display("%0t: channel_number exp %0d got %0d", $time, e.ch, out_channel_number);
          fail_cnt++;
        end
        if (out_pixel_end !== e.pe) begin
          $display("%0t: pixel_end exp %b got %b", $time, e.pe, out_pixel_end);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end else if (quiet) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_cnt = 0;
    idle_cycles = 0;
    hold_req = 0;
    quiet = 0;
    sender_idle = 0;
    ch_cnt = 0;
    el_cnt = 0;
    reg_channels = 1;
    reg_pool = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (i == 6) begin
        wait_drained();
        write_reg(CFG_CHANNEL_COUNT, 32'd0);
        write_reg(CFG_POOL_SIZE, 32'd3);
      end
      send_word(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].exp_val, dir_rows[i].exp_idx);
    end
    wait_drained();

    run_phase(2047, 1, 60);
    run_phase(1024, 0, 40);
    run_phase(1, 500, 258);
    for (int p = 0; p < 8; p++)
      run_phase($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(10, 20));
    run_phase(2, 2, 10);

    // long receiver hold while the sender keeps pushing
    hold_req = 1;
    sender_idle = 1;
    run_phase(3, 1, 60);
    sender_idle = 0;

    run_phase(5, 3, 30);
    quiet = 1;
    run_phase(4, 2, 32);

    if (fail_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
